// File: rtl/fsfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free segment fit allocator package
// Shared types and codes for the segment table sequencer and its fit unit.
// ----------------------------------------------------------------------------
package fsfa_pkg;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_ALLOC  = 1'b1;

   localparam logic STRATEGY_FIRST_FIT = 1'b0;
   localparam logic STRATEGY_BEST_FIT  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ALLOCATED = 2'd0,
      STATUS_NO_FIT    = 2'd1,
      STATUS_INSERTED  = 2'd2,
      STATUS_FULL      = 2'd3
   } fsfa_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_SHIFT,
      S_REPLY
   } fsfa_state_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] seg_start;
      logic [15:0] seg_size;
      logic [15:0] req_size;
   } fsfa_cmd_type;

   typedef struct packed {
      fsfa_status_type status;
      logic [15:0]     alloc_addr;
   } fsfa_result_type;

   typedef struct packed {
      logic        take;
      logic [15:0] remain;
   } fsfa_fit_type;

endpackage
`default_nettype wire

// File: rtl/fsfa_fit_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free segment fit unit
// Compares one table entry against the request and the best entry so far and
// computes the shrunken size and advanced start of that entry.
// ----------------------------------------------------------------------------
module fsfa_fit_unit
   import fsfa_pkg::*;
#(
   parameter int ADDR_BITS = 16
) (
   input  logic [ADDR_BITS-1:0] cand_start,
   input  logic [15:0]          cand_size,
   input  logic [15:0]          req_size,
   input  logic [15:0]          best_size,
   input  logic                 best_found,
   input  logic                 strategy_mode,
   output fsfa_fit_type         fit,
   output logic [ADDR_BITS-1:0] next_start
);

   logic [16:0] diff_c;
   logic        fits_c;
   logic        smaller_c;

   always_comb begin
      diff_c     = {1'b0, cand_size} - {1'b0, req_size};
      fits_c     = ~diff_c[16];
      smaller_c  = cand_size < best_size;
      fit.take   = fits_c && (!best_found ||
                   (strategy_mode == STRATEGY_BEST_FIT && smaller_c));
      fit.remain = diff_c[15:0];
      next_start = cand_start + ADDR_BITS'(req_size);
   end

endmodule
`default_nettype wire

// File: rtl/fsfa_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free segment fit allocator sequencer
// Holds the segment table in memory, scans it from the last entry to the first, one entry per
// cycle through the fit unit, updates the chosen entry and compacts the table.
// ----------------------------------------------------------------------------
module fsfa_engine
   import fsfa_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16,
   parameter int ADDR_BITS    = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            strategy_mode,
   input  logic            cmd_valid,
   input  fsfa_cmd_type    cmd,
   output logic            busy,
   output logic            result_valid,
   input  logic            result_taken,
   output fsfa_result_type result
);

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);

   logic [ADDR_BITS-1:0] start_mem [MAX_SEGMENTS];
   logic [15:0]          size_mem  [MAX_SEGMENTS];

   fsfa_state_type       state_ff, state_in;
   logic [CW-1:0]        used_ff, used_in;
   logic [15:0]          req_size_ff, req_size_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        pick_ff, pick_in;
   logic [15:0]          best_size_ff, best_size_in;
   logic [ADDR_BITS-1:0] best_start_ff, best_start_in;
   logic [15:0]          best_remain_ff, best_remain_in;
   logic [ADDR_BITS-1:0] best_next_ff, best_next_in;
   fsfa_result_type      result_ff, result_in;

   logic [IW-1:0]        rd_idx_ff;
   logic [ADDR_BITS-1:0] rd_start_ff;
   logic [15:0]          rd_size_ff;

   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   logic [ADDR_BITS-1:0] mem_wstart;
   logic [15:0]          mem_wsize;
   logic                 mem_re;
   logic [IW-1:0]        mem_raddr;

   logic [CW-1:0]        used_dec_c;
   logic [CW-1:0]        pick_inc_c;
   logic [CW-1:0]        rd_inc_c;

   fsfa_fit_type         fit;
   logic [ADDR_BITS-1:0] fit_next_start;

   fsfa_fit_unit #(
      .ADDR_BITS(ADDR_BITS)
   ) u_fit (
      .cand_start   (rd_start_ff),
      .cand_size    (rd_size_ff),
      .req_size     (req_size_ff),
      .best_size    (best_size_ff),
      .best_found   (found_ff),
      .strategy_mode(strategy_mode),
      .fit          (fit),
      .next_start   (fit_next_start)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         start_mem[mem_waddr] <= mem_wstart;
         size_mem[mem_waddr]  <= mem_wsize;
      end
      if (mem_re) begin
         rd_start_ff <= start_mem[mem_raddr];
         rd_size_ff  <= size_mem[mem_raddr];
         rd_idx_ff   <= mem_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff    <= req_size_in;
      found_ff       <= found_in;
      pick_ff        <= pick_in;
      best_size_ff   <= best_size_in;
      best_start_ff  <= best_start_in;
      best_remain_ff <= best_remain_in;
      best_next_ff   <= best_next_in;
      result_ff      <= result_in;
   end

   always_comb begin
      used_dec_c = used_ff - CW'(1);
      pick_inc_c = CW'(pick_ff) + CW'(1);
      rd_inc_c   = CW'(rd_idx_ff) + CW'(1);

      state_in       = state_ff;
      used_in        = used_ff;
      req_size_in    = req_size_ff;
      found_in       = found_ff;
      pick_in        = pick_ff;
      best_size_in   = best_size_ff;
      best_start_in  = best_start_ff;
      best_remain_in = best_remain_ff;
      best_next_in   = best_next_ff;
      result_in      = result_ff;

      mem_we     = 1'b0;
      mem_waddr  = used_ff[IW-1:0];
      mem_wstart = rd_start_ff;
      mem_wsize  = rd_size_ff;
      mem_re     = 1'b0;
      mem_raddr  = used_dec_c[IW-1:0];

      result_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               result_in.alloc_addr = '0;
               state_in             = S_REPLY;
               if (cmd.kind == KIND_INSERT) begin
                  if (used_ff == CW'(MAX_SEGMENTS)) begin
                     result_in.status = STATUS_FULL;
                  end else begin
                     mem_we           = 1'b1;
                     mem_waddr        = used_ff[IW-1:0];
                     mem_wstart       = ADDR_BITS'(cmd.seg_start);
                     mem_wsize        = cmd.seg_size;
                     used_in          = used_ff + CW'(1);
                     result_in.status = STATUS_INSERTED;
                  end
               end else if (used_ff == '0) begin
                  result_in.status = STATUS_NO_FIT;
               end else begin
                  mem_re      = 1'b1;
                  mem_raddr   = used_dec_c[IW-1:0];
                  req_size_in = cmd.req_size;
                  found_in    = 1'b0;
                  state_in    = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (fit.take) begin
               found_in       = 1'b1;
               pick_in        = rd_idx_ff;
               best_size_in   = rd_size_ff;
               best_start_in  = rd_start_ff;
               best_remain_in = fit.remain;
               best_next_in   = fit_next_start;
            end
            if ((fit.take && strategy_mode == STRATEGY_FIRST_FIT) || rd_idx_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = rd_idx_ff - IW'(1);
            end
         end
         S_FINISH: begin
            state_in = S_REPLY;
            if (!found_ff) begin
               result_in.status     = STATUS_NO_FIT;
               result_in.alloc_addr = '0;
            end else begin
               result_in.status     = STATUS_ALLOCATED;
               result_in.alloc_addr = 16'(best_start_ff);
               if (best_remain_ff != '0) begin
                  mem_we     = 1'b1;
                  mem_waddr  = pick_ff;
                  mem_wstart = best_next_ff;
                  mem_wsize  = best_remain_ff;
               end else if (pick_inc_c < used_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = pick_inc_c[IW-1:0];
                  state_in  = S_SHIFT;
               end else begin
                  used_in = used_dec_c;
               end
            end
         end
         S_SHIFT: begin
            mem_we     = 1'b1;
            mem_waddr  = rd_idx_ff - IW'(1);
            mem_wstart = rd_start_ff;
            mem_wsize  = rd_size_ff;
            if (rd_inc_c < used_ff) begin
               mem_re    = 1'b1;
               mem_raddr = rd_inc_c[IW-1:0];
            end else begin
               used_in  = used_dec_c;
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            result_valid = 1'b1;
            if (result_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy   = (state_ff != S_IDLE);
   assign result = result_ff;

endmodule
`default_nettype wire

// File: rtl/free_segment_fit_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An insert, or an allocation from an empty table, needs no scan; its response passes through
// the engine's result register and then the response register. Any other allocation scans E
// entries (one per cycle through the segment memory's one read port) and moves K entries when
// a segment empties, with E at most MAX_SEGMENTS.
// Reset clears the entry count, the strategy and the response valid flag; the table memory is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Free segment fit allocator
// First fit or best fit allocation from an ordered table of free segments.
// ----------------------------------------------------------------------------
module free_segment_fit_allocator_unit
   import fsfa_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16,
   parameter int ADDR_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [15:0] req_seg_start,
   input  logic [15:0] req_seg_size,
   input  logic [15:0] req_req_size,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_alloc_addr
);

   logic            strategy_ff, strategy_in;
   logic            rsp_valid_ff, rsp_valid_in;
   fsfa_result_type rsp_result_ff, rsp_result_in;

   fsfa_cmd_type    cmd;
   logic            cmd_valid;
   logic            eng_busy;
   logic            eng_result_valid;
   logic            eng_result_taken;
   fsfa_result_type eng_result;

   assign cmd.kind      = req_kind;
   assign cmd.seg_start = req_seg_start;
   assign cmd.seg_size  = req_seg_size;
   assign cmd.req_size  = req_req_size;
   assign cmd_valid     = req_valid && !eng_busy;

   fsfa_engine #(
      .MAX_SEGMENTS(MAX_SEGMENTS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .strategy_mode(strategy_ff),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .busy         (eng_busy),
      .result_valid (eng_result_valid),
      .result_taken (eng_result_taken),
      .result       (eng_result)
   );

   always_comb begin
      strategy_in      = csr_wr_en ? csr_wr_data : strategy_ff;
      eng_result_taken = eng_result_valid && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_result_in    = rsp_result_ff;
      if (eng_result_taken) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = eng_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff  <= STRATEGY_FIRST_FIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         strategy_ff  <= strategy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
   end

   assign req_stall      = eng_busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_result_ff.status;
   assign rsp_alloc_addr = rsp_result_ff.alloc_addr;

endmodule
`default_nettype wire

// File: rtl/fsfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free segment fit allocator checker
// Port level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fsfa_checker
   import fsfa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_alloc_addr
);

   // A response held back by the consumer stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Stalled response was withdrawn.");

   // A response that is not a grant carries a zero address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_ALLOCATED |-> rsp_alloc_addr == 16'd0)
      else $error("Non-grant response carries an address.");

   // The block works on one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Input accepted while a transaction is in progress.");

   // A new response appears only after an input transaction was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("Response appeared without a transaction in progress.");

endmodule

bind free_segment_fit_allocator_unit fsfa_checker u_fsfa_checker (.*);
`default_nettype wire
